// ----- hw/rtl/dsmf_pkg.sv -----
// Shared types and constants for the dot-stuffed message framer.
`default_nettype none
package dsmf_pkg;
	localparam int LineCountBits = 21;
	localparam int LimitBits = 21;
	localparam int CmpBits = (LineCountBits > LimitBits) ? LineCountBits : LimitBits;
	localparam int QueueDepth = 4;
	localparam int QueueAddrBits = $clog2(QueueDepth);

	localparam logic [7:0] ChDot = 8'h2E;
	localparam logic [7:0] ChLf = 8'h0A;
	localparam logic [7:0] ChCr = 8'h0D;

	// one queued step: which output segments to send, in fixed order
	typedef struct packed {
		logic held_cr;
		logic stuff_dot;
		logic send_char;
		logic crlf;
		logic close;
		logic [7:0] data;
	} plan_t;
endpackage
`default_nettype wire

// ----- hw/rtl/dsmf_if.sv -----
// Channel interfaces for the dot-stuffed message framer.
`default_nettype none
interface dsmf_msg_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic has_byte;
	logic end_of_message;
	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface dsmf_frm_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_of_message;
	modport source (output valid, out_byte, last_of_message, input ready);
	modport sink (input valid, out_byte, last_of_message, output ready);
endinterface

interface dsmf_cfg_if;
	logic valid;
	logic ready;
	logic signed [dsmf_pkg::LimitBits-1:0] body_line_limit;
	modport source (output valid, body_line_limit, input ready);
	modport sink (input valid, body_line_limit, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dsmf_front.sv -----
// Front end: accepts message words, tracks line state, builds output plans.
`default_nettype none
module dsmf_front (
	input  wire logic clk,
	input  wire logic arst_n,
	dsmf_msg_if.sink msg,
	dsmf_cfg_if.sink cfg,
	input  wire logic q_full,
	output logic q_push,
	output dsmf_pkg::plan_t q_entry
);
	logic signed [dsmf_pkg::LimitBits-1:0] limit_q;
	logic in_body_q;
	logic [dsmf_pkg::LineCountBits-1:0] count_q;
	logic lhc_q;
	logic crp_q;
	logic sup_q;

	logic accept;
	logic hit_limit;
	logic sup_now;
	logic act;
	logic is_lf;
	logic is_cr;
	logic lhc_n;
	logic crp_n;
	logic in_body_n;
	logic [dsmf_pkg::LineCountBits-1:0] count_n;
	dsmf_pkg::plan_t plan;

	assign cfg.ready = 1'b1;
	assign msg.ready = !q_full;
	assign accept = msg.valid && msg.ready;

	assign hit_limit = !limit_q[dsmf_pkg::LimitBits-1] &&
		(dsmf_pkg::CmpBits'(count_q) >=
		 dsmf_pkg::CmpBits'(limit_q[dsmf_pkg::LimitBits-2:0]));
	assign sup_now = sup_q || (msg.has_byte && !lhc_q && !crp_q && in_body_q && hit_limit);
	assign act = msg.has_byte && !sup_now;
	assign is_lf = msg.data_byte == dsmf_pkg::ChLf;
	assign is_cr = msg.data_byte == dsmf_pkg::ChCr;

	always_comb begin
		lhc_n = lhc_q;
		crp_n = crp_q;
		in_body_n = in_body_q;
		count_n = count_q;
		if (act) begin
			if (is_lf) begin
				if (in_body_q) begin
					if (count_q != '1) begin
						count_n = count_q + 1'b1;
					end
				end else if (!lhc_q) begin
					in_body_n = 1'b1;
				end
				lhc_n = 1'b0;
				crp_n = 1'b0;
			end else if (is_cr) begin
				lhc_n = lhc_q || crp_q;
				crp_n = 1'b1;
			end else begin
				lhc_n = 1'b1;
				crp_n = 1'b0;
			end
		end
	end

	always_comb begin
		plan.held_cr = act && !is_lf && crp_q;
		plan.send_char = act && !is_lf && !is_cr;
		plan.stuff_dot = plan.send_char && !lhc_q && !crp_q &&
			(msg.data_byte == dsmf_pkg::ChDot);
		plan.crlf = (act && is_lf) ||
			(msg.end_of_message && !sup_now && (lhc_n || crp_n));
		plan.close = msg.end_of_message;
		plan.data = msg.data_byte;
	end

	assign q_entry = plan;
	assign q_push = accept && (plan.held_cr || plan.send_char || plan.crlf || plan.close);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
			in_body_q <= 1'b0;
			count_q <= '0;
			lhc_q <= 1'b0;
			crp_q <= 1'b0;
			sup_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.body_line_limit;
			end
			if (accept) begin
				if (msg.end_of_message) begin
					in_body_q <= 1'b0;
					count_q <= '0;
					lhc_q <= 1'b0;
					crp_q <= 1'b0;
					sup_q <= 1'b0;
				end else begin
					in_body_q <= in_body_n;
					count_q <= count_n;
					lhc_q <= lhc_n;
					crp_q <= crp_n;
					sup_q <= sup_now;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/dsmf_queue.sv -----
// Plan queue between front and back ends.
`default_nettype none
module dsmf_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire dsmf_pkg::plan_t push_entry,
	output logic full,
	input  wire logic pop,
	output dsmf_pkg::plan_t pop_entry,
	output logic empty
);
	dsmf_pkg::plan_t mem [dsmf_pkg::QueueDepth];
	logic [dsmf_pkg::QueueAddrBits-1:0] wr_q;
	logic [dsmf_pkg::QueueAddrBits-1:0] rd_q;
	logic [dsmf_pkg::QueueAddrBits:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = cnt_q == (dsmf_pkg::QueueAddrBits+1)'(dsmf_pkg::QueueDepth);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_entry = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/dsmf_back.sv -----
// Back end: expands one plan into output words, one per cycle while frm.ready is high.
`default_nettype none
module dsmf_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire dsmf_pkg::plan_t q_entry,
	output logic q_pop,
	dsmf_frm_if.source frm
);
	// slots: 0 CR, 1 dot, 2 char, 3 CR, 4 LF, 5 dot, 6 CR, 7 LF (last)
	logic [7:0] slot_q;
	logic [7:0] data_q;
	logic [7:0] first;
	logic [7:0] rest;
	logic [7:0] load_slots;
	logic take;
	logic load;

	assign first = slot_q & (~slot_q + 8'd1);
	assign rest = slot_q & ~first;
	assign take = frm.valid && frm.ready;
	assign load = !q_empty && ((slot_q == '0) || (take && rest == '0));
	assign q_pop = load;
	assign load_slots = {q_entry.close, q_entry.close, q_entry.close,
		q_entry.crlf, q_entry.crlf, q_entry.send_char, q_entry.stuff_dot, q_entry.held_cr};

	assign frm.valid = slot_q != '0;
	assign frm.last_of_message = first[7];

	always_comb begin
		if (first[0] || first[3] || first[6]) begin
			frm.out_byte = dsmf_pkg::ChCr;
		end else if (first[1] || first[5]) begin
			frm.out_byte = dsmf_pkg::ChDot;
		end else if (first[2]) begin
			frm.out_byte = data_q;
		end else begin
			frm.out_byte = dsmf_pkg::ChLf;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= q_entry.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (load) begin
			slot_q <= load_slots;
		end else if (take) begin
			slot_q <= rest;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/dot_stuffed_message_framer_top.sv -----
// Dot-stuffed message framer: front end, plan queue and back end.
// An accepted word's plan is registered in the plan queue, then in the back end's slot register.
// Throughput: one input word per cycle while the queue has room, one output word
// per cycle while frm is ready, up to seven per input; the queue absorbs bursts.
// Reset: arst_n clears line state and the queue; the line limit returns to -1.
`default_nettype none
module dot_stuffed_message_framer_top (
	input  wire logic clk,
	input  wire logic arst_n,
	dsmf_msg_if.sink msg,
	dsmf_cfg_if.sink cfg,
	dsmf_frm_if.source frm
);
	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	dsmf_pkg::plan_t push_entry;
	dsmf_pkg::plan_t pop_entry;

	dsmf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg),
		.cfg(cfg),
		.q_full(q_full),
		.q_push(q_push),
		.q_entry(push_entry)
	);

	dsmf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_entry(push_entry),
		.full(q_full),
		.pop(q_pop),
		.pop_entry(pop_entry),
		.empty(q_empty)
	);

	dsmf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_entry(pop_entry),
		.q_pop(q_pop),
		.frm(frm)
	);
endmodule
`default_nettype wire
